### hw/rtl/sdis_pkg.sv
// Shared types and constants for the stable descending index sort.
package sdis_pkg;

    // Field widths fixed by the item format.
    localparam int HEAT_W        = 64;
    localparam int POS_W         = 6;
    localparam int MAX_ITEMS_DEF = 64;

    // Contents of one sorting cell: a key and the arrival position it came with.
    typedef struct packed {
        logic signed [HEAT_W-1:0] key;
        logic        [POS_W-1:0]  pos;
    } t_cell;

    // Per-cycle command broadcast from the controller to every cell.
    typedef struct packed {
        logic insert;  // place the new beat into the chain
        logic drain;   // shift the chain one cell toward the head
    } t_cell_ctrl;

endpackage

### hw/rtl/sdis_cell.sv
// One cell of the systolic insertion chain.
module sdis_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                    i_clk,
    input  sdis_pkg::t_cell_ctrl    i_ctrl,
    input  logic [CNT_W-1:0]        i_count,
    input  sdis_pkg::t_cell         i_new,
    input  sdis_pkg::t_cell         i_prev,
    input  logic                    i_prev_take,
    input  sdis_pkg::t_cell         i_next,
    output sdis_pkg::t_cell         o_cell,
    output logic                    o_take
);
    import sdis_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    t_cell r_cell;
    t_cell n_cell;

    // The new key belongs at or before this cell when the cell is empty or
    // holds a strictly smaller key; equal keys stay ahead, keeping the sort stable.
    assign o_take = (IDX_C >= i_count) || (r_cell.key < i_new.key);

    // Insert pushes the tail down one cell; drain pulls the chain toward the head.
    always_comb begin
        n_cell = r_cell;
        if (i_ctrl.insert) begin
            if (i_prev_take) begin
                n_cell = i_prev;
            end else if (o_take) begin
                n_cell = i_new;
            end
        end else if (i_ctrl.drain) begin
            n_cell = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

### hw/rtl/stable_descending_index_sort.sv
// Top level of the stable descending index sort: controller and cell chain.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+-------------------------------------
//  item in  | start, busy                 | i_heat, i_last
//  result   | o_res_strobe (no backpress) | o_position, o_overflow, o_final_res
//  config   | i_cfg_valid, o_cfg_ready    | i_cfg_data (order_by_heat)
//
// Items are taken one per cycle while busy is low; each beat is inserted into
// the cell chain in the same cycle, or dropped and flagged as overflow when full.
// After the beat marked last, busy rises and one result per stored item follows
// on consecutive cycles, set by the single shift of the chain toward its head.
// The next item is taken in the cycle after the final result.
// Reset is synchronous and clears the run count, drop flag and controller;
// results cannot be stalled.
module stable_descending_index_sort #(
    parameter int MAX_ITEMS = sdis_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sdis_pkg::HEAT_W-1:0] i_heat,
    input  logic                              i_last,
    output logic                              o_res_strobe,
    output logic        [sdis_pkg::POS_W-1:0] o_position,
    output logic                              o_overflow,
    output logic                              o_final_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data
);
    import sdis_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ITEMS);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    logic [POS_W-1:0]  r_idx;
    logic              r_dropped;
    logic              r_order;
    logic              r_sort;

    t_cell_ctrl        w_ctrl;
    t_cell             w_new;
    t_cell             w_cell [MAX_ITEMS];
    logic              w_take [MAX_ITEMS];
    logic              w_accept;
    logic              w_full;

    assign w_accept = start && (r_state == ST_IDLE);
    assign w_full   = (r_count == MAX_C);

    assign w_new.key = i_heat;
    assign w_new.pos = POS_W'(r_count);

    assign w_ctrl.insert = w_accept && !w_full;
    assign w_ctrl.drain  = (r_state == ST_DRAIN);

    // Chain of cells; the head is cell 0 and holds the hottest stored key.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_cell w_prev;
        t_cell w_next;
        logic  w_prev_take;

        if (g == 0) begin : g_head
            assign w_prev      = w_new;
            assign w_prev_take = 1'b0;
        end else begin : g_body
            assign w_prev      = w_cell[g-1];
            assign w_prev_take = w_take[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_next = w_cell[g];
        end else begin : g_inner
            assign w_next = w_cell[g+1];
        end

        sdis_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_count     (r_count),
            .i_new       (w_new),
            .i_prev      (w_prev),
            .i_prev_take (w_prev_take),
            .i_next      (w_next),
            .o_cell      (w_cell[g]),
            .o_take      (w_take[g])
        );
    end

    // Run controller: counts stored items, records drops, latches the order and paces the drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_idx     <= '0;
            r_dropped <= 1'b0;
            r_order   <= 1'b1;
            r_sort    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_order <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_last) begin
                            r_state <= ST_DRAIN;
                            r_left  <= w_full ? r_count : r_count + 1'b1;
                            r_idx   <= '0;
                            r_sort  <= r_order;
                        end
                    end
                end
                ST_DRAIN: begin
                    r_left <= r_left - 1'b1;
                    r_idx  <= r_idx + 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        r_state   <= ST_IDLE;
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // One result beat per drain cycle, taken from the head of the chain when sorting, else the drain index.
    assign busy         = (r_state == ST_DRAIN);
    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = (r_state == ST_DRAIN);
    assign o_position   = r_sort ? w_cell[0].pos : r_idx;
    assign o_overflow   = r_dropped;
    assign o_final_res  = (r_state == ST_DRAIN) && (r_left == CNT_W'(1));

endmodule

### hw/rtl/sdis_checker.sv
// Port-level checker for the stable descending index sort, with its bind.
module sdis_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last,
    input logic o_res_strobe,
    input logic o_final_res
);

    // A final beat closes the run and frees the item port.
    a_final_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_final_res |=> !busy)
        else $error("busy still high after final result beat");

    // Accepting the last item starts the result stream in the next cycle.
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last |=> busy && o_res_strobe)
        else $error("no result beat after last item");

    // Results never pause before the final one.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_final_res |=> o_res_strobe)
        else $error("gap in result stream");

    // The item port is closed exactly while results are emitted.
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy == o_res_strobe)
        else $error("busy and result strobe disagree");

endmodule

bind stable_descending_index_sort sdis_checker u_sdis_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_last       (i_last),
    .o_res_strobe (o_res_strobe),
    .o_final_res  (o_final_res)
);
